// ----- src/ballistic_impact_threat_check_core_defines.svh -----
// Assertion macros shared by the threat check RTL.
// No dependencies; included by the modules that carry checks.
`ifndef BALLISTIC_IMPACT_THREAT_CHECK_CORE_DEFINES_SVH
`define BALLISTIC_IMPACT_THREAT_CHECK_CORE_DEFINES_SVH
`ifndef SYNTH
`define BTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BTC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BTC_ASSERT(lbl, prop, msg)
`define BTC_NEVER(lbl, cond, msg)
`endif
`endif

// ----- src/btc_pkg.sv -----
// Shared types and constants for the ballistic impact threat check.
// No dependencies.
package btc_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    V_THREAT      = 3'd0,
    V_GROUNDED    = 3'd1,
    V_LEFT        = 3'd2,
    V_NO_ROOT     = 3'd3,
    V_NO_POS_TIME = 3'd4,
    V_OUTSIDE     = 3'd5
  } verdict_e;

  // register indexes
  localparam logic [1:0] REG_GROUND = 2'd0;
  localparam logic [1:0] REG_LEFT   = 2'd1;
  localparam logic [1:0] REG_RIGHT  = 2'd2;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // queue entry: pos_x, vel_x, vel_y, grav, idle, calc, verdict, radicand
  function automatic int entry_width(int w);
    return 6 * w + 5;
  endfunction

endpackage

// ----- src/ballistic_impact_threat_check_core.sv -----
// Throughput: one track per cycle while the output is not stalled; the root and
// divide units are pipelined one bit per stage.
// A four-entry queue splits the classifying front end from the arithmetic back end.
// Reset (rst_ni low, asynchronous) empties all stages; the three registers clear to zero.
// No clearing pass: the block takes tracks in the first cycle after reset.
module ballistic_impact_threat_check_core #(
  parameter int DATA_WIDTH = btc_pkg::DATA_WIDTH_DEF,
  localparam int PW = (DATA_WIDTH > 32) ? 64 : 32,
  localparam int AW = (DATA_WIDTH > 32) ? 5 : 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [DATA_WIDTH-1:0] pos_x_i,
  input  logic [DATA_WIDTH-1:0] pos_y_i,
  input  logic [DATA_WIDTH-1:0] vel_x_i,
  input  logic [DATA_WIDTH-1:0] vel_y_i,
  input  logic [DATA_WIDTH-2:0] grav_i,
  input  logic                  interceptor_idle_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  threat_o,
  output logic                  launch_o,
  output logic [DATA_WIDTH-1:0] impact_x_o,
  output logic [2:0]            verdict_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [AW-1:0]         paddr,
  input  logic [PW-1:0]         pwdata,
  output logic [PW-1:0]         prdata,
  output logic                  pready
);
  import btc_pkg::*;
  localparam int EW = entry_width(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] ground_q, left_q, right_q;
  logic [1:0]            idx;
  logic                  wr;
  logic                  push, pop;
  logic [EW-1:0]         ent_in, ent_out;
  queue_stat_t           q_stat;

  // register port
  assign pready = 1'b1;
  assign idx    = paddr[AW-1:AW-2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ground_q <= '0;
      left_q   <= '0;
      right_q  <= '0;
    end else if (wr) begin
      case (idx)
        REG_GROUND: ground_q <= pwdata[DATA_WIDTH-1:0];
        REG_LEFT:   left_q   <= pwdata[DATA_WIDTH-1:0];
        REG_RIGHT:  right_q  <= pwdata[DATA_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GROUND: prdata = PW'(ground_q);
      REG_LEFT:   prdata = PW'(left_q);
      REG_RIGHT:  prdata = PW'(right_q);
      default:    prdata = '0;
    endcase
  end

  btc_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .pos_x_i, .pos_y_i, .vel_x_i, .vel_y_i, .grav_i, .interceptor_idle_i,
    .ground_i (ground_q),
    .left_i   (left_q),
    .q_stat_i (q_stat),
    .push_o   (push),
    .entry_o  (ent_in)
  );

  btc_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni,
    .push_i (push),
    .data_i (ent_in),
    .pop_i  (pop),
    .data_o (ent_out),
    .stat_o (q_stat)
  );

  btc_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .entry_i  (ent_out),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .left_i   (left_q),
    .right_i  (right_q),
    .out_valid_o, .out_stall_i, .threat_o, .launch_o, .impact_x_o, .verdict_o
  );

endmodule

// ----- src/btc_front.sv -----
// Front end: takes a track, classifies it and forms the radicand.
// Depends on btc_pkg.
module btc_front #(
  parameter int DATA_WIDTH = btc_pkg::DATA_WIDTH_DEF,
  localparam int EW = btc_pkg::entry_width(DATA_WIDTH)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [DATA_WIDTH-1:0]   pos_x_i,
  input  logic [DATA_WIDTH-1:0]   pos_y_i,
  input  logic [DATA_WIDTH-1:0]   vel_x_i,
  input  logic [DATA_WIDTH-1:0]   vel_y_i,
  input  logic [DATA_WIDTH-2:0]   grav_i,
  input  logic                    interceptor_idle_i,
  input  logic [DATA_WIDTH-1:0]   ground_i,
  input  logic [DATA_WIDTH-1:0]   left_i,
  input  btc_pkg::queue_stat_t    q_stat_i,
  output logic                    push_o,
  output logic [EW-1:0]           entry_o
);
  import btc_pkg::*;
  localparam int W = DATA_WIDTH;

  logic           adv;
  logic           v1_q, v2_q;
  logic [W-1:0]   px1_q, py1_q, vx1_q, vy1_q;
  logic [W-2:0]   g1_q;
  logic           idle1_q;
  logic [W-1:0]   px2_q, vx2_q, vy2_q;
  logic [W-2:0]   g2_q;
  logic           idle2_q, calc2_q;
  logic [2:0]     ev2_q;
  logic [2*W-1:0] sq2_q;
  logic [2*W-2:0] gd2_q;

  logic           grounded, left_of, gzero;
  logic [W-1:0]   height, avy;
  logic [2*W-1:0] sq;
  logic [2*W-2:0] gd;
  logic [2*W:0]   rad;

  // the two stages move together whenever the last one can empty
  assign adv        = !v2_q || !q_stat_i.full;
  assign in_stall_o = !adv;
  assign push_o     = v2_q && !q_stat_i.full;

  // classification and products
  always_comb begin
    grounded = $signed(py1_q) >= $signed(ground_i);
    left_of  = $signed(px1_q) < $signed(left_i);
    gzero    = (g1_q == '0);
    height   = ground_i - py1_q;
    avy      = vy1_q[W-1] ? (~vy1_q + 1'b1) : vy1_q;
    sq       = avy * avy;
    gd       = g1_q * height;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px1_q   <= pos_x_i;
      py1_q   <= pos_y_i;
      vx1_q   <= vel_x_i;
      vy1_q   <= vel_y_i;
      g1_q    <= grav_i;
      idle1_q <= interceptor_idle_i;
      px2_q   <= px1_q;
      vx2_q   <= vx1_q;
      vy2_q   <= vy1_q;
      g2_q    <= g1_q;
      idle2_q <= idle1_q;
      calc2_q <= !grounded && !left_of && !gzero;
      ev2_q   <= grounded ? V_GROUNDED : (left_of ? V_LEFT : V_NO_POS_TIME);
      sq2_q   <= sq;
      gd2_q   <= gd;
    end
  end

  // radicand vy^2 + 2*g*height
  assign rad     = {1'b0, sq2_q} + {1'b0, gd2_q, 1'b0};
  assign entry_o = {px2_q, vx2_q, vy2_q, g2_q, idle2_q, calc2_q, ev2_q, rad};

endmodule

// ----- src/btc_queue.sv -----
// Small register queue between front and back ends.
// Depends on btc_pkg and the assertion macro header.
`include "ballistic_impact_threat_check_core_defines.svh"
module btc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = btc_pkg::QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [WIDTH-1:0]      data_i,
  input  logic                  pop_i,
  output logic [WIDTH-1:0]      data_o,
  output btc_pkg::queue_stat_t  stat_o
);
  import btc_pkg::*;
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [AW:0]      cnt_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == (AW+1)'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  `BTC_NEVER(a_q_over, cnt_q > (AW+1)'(DEPTH), "queue count over depth")
  `BTC_ASSERT(a_q_inc, do_push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1, "count not bumped")
  `BTC_ASSERT(a_q_ptr, stat_o.empty |-> wr_q == rd_q, "empty queue with pointer gap")

endmodule

// ----- src/btc_back.sv -----
// Back end: pipelined root, product, divide and city test.
// Depends on btc_pkg and the assertion macro header.
`include "ballistic_impact_threat_check_core_defines.svh"
module btc_back #(
  parameter int DATA_WIDTH = btc_pkg::DATA_WIDTH_DEF,
  localparam int EW = btc_pkg::entry_width(DATA_WIDTH)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [EW-1:0]           entry_i,
  input  btc_pkg::queue_stat_t    q_stat_i,
  output logic                    pop_o,
  input  logic [DATA_WIDTH-1:0]   left_i,
  input  logic [DATA_WIDTH-1:0]   right_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    threat_o,
  output logic                    launch_o,
  output logic [DATA_WIDTH-1:0]   impact_x_o,
  output logic [2:0]              verdict_o
);
  import btc_pkg::*;
  localparam int W   = DATA_WIDTH;
  localparam int CW  = 4 * W + 4;
  localparam int RW  = 2 * W + 2;
  localparam int NR  = W + 1;
  localparam int RMW = W + 4;
  localparam int QW  = W + 1;
  localparam int ND  = W + 1;

  logic en;

  // root stages
  logic           sq_v_q   [NR+1];
  logic [CW-1:0]  sq_c_q   [NR+1];
  logic [RW-1:0]  sq_rad_q [NR+1];
  logic [RMW-1:0] sq_rem_q [NR+1];
  logic [QW-1:0]  sq_rt_q  [NR+1];

  // numerator and product stages
  logic           cs_v_q, md_v_q;
  logic [CW-1:0]  cs_c_q, md_c_q;
  logic [W:0]     cs_num_q;
  logic [W-1:0]   cs_avx_q;
  logic [2*W:0]   md_n_q;

  // divide stages
  logic           dv_v_q   [ND+1];
  logic [CW-1:0]  dv_c_q   [ND+1];
  logic [W-2:0]   dv_rem_q [ND+1];
  logic [W:0]     dv_low_q [ND+1];
  logic [QW-1:0]  dv_q_q   [ND+1];
  logic           dv_sat_q [ND+1];

  // output register
  logic           ov_q, othr_q, olch_q;
  logic [W-1:0]   oix_q;
  logic [2:0]     ovd_q;

  assign en    = !(ov_q && out_stall_i);
  assign pop_o = en;

  // load from queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sq_v_q[0] <= 1'b0;
    else if (en) sq_v_q[0] <= !q_stat_i.empty;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_c_q[0]   <= entry_i[EW-1:2*W+1];
      sq_rad_q[0] <= {1'b0, entry_i[2*W:0]};
      sq_rem_q[0] <= '0;
      sq_rt_q[0]  <= '0;
    end
  end

  // one root bit per stage
  for (genvar k = 1; k <= NR; k++) begin : g_sqrt
    logic [RMW-1:0] remsh, trial;
    logic           ge;
    assign remsh = {sq_rem_q[k-1][RMW-3:0], sq_rad_q[k-1][RW-1:RW-2]};
    assign trial = {1'b0, sq_rt_q[k-1], 2'b01};
    assign ge    = remsh >= trial;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sq_v_q[k] <= 1'b0;
      else if (en) sq_v_q[k] <= sq_v_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_c_q[k]   <= sq_c_q[k-1];
        sq_rad_q[k] <= {sq_rad_q[k-1][RW-3:0], 2'b00};
        sq_rem_q[k] <= ge ? (remsh - trial) : remsh;
        sq_rt_q[k]  <= {sq_rt_q[k-1][QW-2:0], ge};
      end
    end
  end

  // rounded-up root minus vel_y
  logic [W+1:0] r_up, vy_ext, num_full;
  logic [W-1:0] vx_c, avx;
  always_comb begin
    vx_c     = sq_c_q[NR][3*W+3:2*W+4];
    avx      = vx_c[W-1] ? (~vx_c + 1'b1) : vx_c;
    r_up     = {1'b0, sq_rt_q[NR]} + (W+2)'(sq_rem_q[NR] != '0);
    vy_ext   = {{2{sq_c_q[NR][2*W+3]}}, sq_c_q[NR][2*W+3:W+4]};
    num_full = r_up - vy_ext;
  end

  logic [2*W:0] prod;
  assign prod = cs_avx_q * cs_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_v_q <= 1'b0;
      md_v_q <= 1'b0;
    end else if (en) begin
      cs_v_q <= sq_v_q[NR];
      md_v_q <= cs_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      cs_c_q   <= sq_c_q[NR];
      cs_num_q <= num_full[W:0];
      cs_avx_q <= avx;
      md_c_q   <= cs_c_q;
      md_n_q   <= prod;
    end
  end

  // divide setup: a high part at or above grav means far past the limit
  logic [W-1:0] hi0;
  assign hi0 = md_n_q[2*W:W+1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_v_q[0] <= 1'b0;
    else if (en) dv_v_q[0] <= md_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_c_q[0]   <= md_c_q;
      dv_sat_q[0] <= hi0 >= {1'b0, md_c_q[W+3:5]};
      dv_rem_q[0] <= hi0[W-2:0];
      dv_low_q[0] <= md_n_q[W:0];
      dv_q_q[0]   <= '0;
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= ND; k++) begin : g_div
    logic [W-1:0] remsh, gx, diff;
    logic         ge;
    assign remsh = {dv_rem_q[k-1], dv_low_q[k-1][W]};
    assign gx    = {1'b0, dv_c_q[k-1][W+3:5]};
    assign ge    = remsh >= gx;
    assign diff  = remsh - gx;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[k] <= 1'b0;
      else if (en) dv_v_q[k] <= dv_v_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_c_q[k]   <= dv_c_q[k-1];
        dv_sat_q[k] <= dv_sat_q[k-1];
        dv_rem_q[k] <= ge ? diff[W-2:0] : remsh[W-2:0];
        dv_low_q[k] <= {dv_low_q[k-1][W-1:0], 1'b0};
        dv_q_q[k]   <= {dv_q_q[k-1][QW-2:0], ge};
      end
    end
  end

  // floor rounding, saturation and city test
  logic [W-1:0] fx, fvx;
  logic         fneg, fcalc, fidle, fthr;
  logic [2:0]   fev, fvd;
  logic [W+1:0] qa, lim, mag, off, ix, vmax, vmin;
  logic [W-1:0] ixc, fix;
  always_comb begin
    fx    = dv_c_q[ND][4*W+3:3*W+4];
    fvx   = dv_c_q[ND][3*W+3:2*W+4];
    fidle = dv_c_q[ND][4];
    fcalc = dv_c_q[ND][3];
    fev   = dv_c_q[ND][2:0];
    fneg  = fvx[W-1];
    lim   = {2'b01, {W{1'b0}}};
    vmax  = {3'b000, {(W-1){1'b1}}};
    vmin  = {3'b111, {(W-1){1'b0}}};
    qa    = {1'b0, dv_q_q[ND]} + (W+2)'(fneg && (dv_rem_q[ND] != '0));
    mag   = (dv_sat_q[ND] || qa > lim) ? lim : qa;
    off   = fneg ? (~mag + 1'b1) : mag;
    ix    = {{2{fx[W-1]}}, fx} + off;
    if ($signed(ix) > $signed(vmax))      ixc = vmax[W-1:0];
    else if ($signed(ix) < $signed(vmin)) ixc = vmin[W-1:0];
    else                                  ixc = ix[W-1:0];
    fthr = fcalc && ($signed(ixc) > $signed(left_i)) && ($signed(ixc) < $signed(right_i));
    fvd  = fcalc ? (fthr ? V_THREAT : V_OUTSIDE) : fev;
    fix  = fcalc ? ixc : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (en) ov_q <= dv_v_q[ND];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      othr_q <= fthr;
      olch_q <= fthr && fidle;
      oix_q  <= fix;
      ovd_q  <= fvd;
    end
  end

  assign out_valid_o = ov_q;
  assign threat_o    = othr_q;
  assign launch_o    = olch_q;
  assign impact_x_o  = oix_q;
  assign verdict_o   = ovd_q;

  `BTC_ASSERT(a_launch, ov_q && olch_q |-> othr_q, "launch without threat")
  `BTC_ASSERT(a_thr_vd, ov_q |-> (othr_q == (ovd_q == V_THREAT)), "threat and verdict disagree")
  `BTC_ASSERT(a_ix_zero, ov_q && ovd_q != V_THREAT && ovd_q != V_OUTSIDE |-> oix_q == '0, "impact_x set on dropped track")

endmodule

// ----- tb/ballistic_impact_threat_check_core_test.sv -----
// Self-checking testbench for ballistic_impact_threat_check_core.
// Depends on btc_pkg and the core RTL; it predicts every verdict and impact point
// internally and compares each output transaction against that prediction.
module ballistic_impact_threat_check_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import btc_pkg::*;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        grav;
    logic               idle;
  } track_t;

  typedef struct {
    logic               threat;
    logic               launch;
    logic signed [31:0] impact_x;
    verdict_e           verdict;
  } outcome_t;

  localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [31:0]        pos_x_i = '0, pos_y_i = '0, vel_x_i = '0, vel_y_i = '0;
  logic [30:0]        grav_i = '0;
  logic               interceptor_idle_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               threat_o, launch_o;
  logic [31:0]        impact_x_o;
  logic [2:0]         verdict_o;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // shadow copy of the configuration registers
  logic signed [31:0] ground_lvl = '0, left_edge = '0, right_edge = '0;

  outcome_t impact_q[$];
  int unsigned mismatch_cnt = 0;
  bit          gaps_on = 1'b1;
  int unsigned hold_req = 0;

  ballistic_impact_threat_check_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // expected outcome of one track under the current registers
  function automatic outcome_t predict_impact(track_t t);
    logic signed [63:0] x, y, vx, vy, gl, lf, rt, num, off, ix;
    logic [63:0]        height, avy, avx, r;
    logic [127:0]       disc, c, prod, q, rem, lim;
    outcome_t           o;
    o.threat = 1'b0;
    o.launch = 1'b0;
    o.impact_x = '0;
    x = t.pos_x;
    y = t.pos_y;
    vx = t.vel_x;
    vy = t.vel_y;
    gl = ground_lvl;
    lf = left_edge;
    rt = right_edge;
    if (y >= gl) begin
      o.verdict = V_GROUNDED;
    end else if (x < lf) begin
      o.verdict = V_LEFT;
    end else if (t.grav == '0) begin
      o.verdict = V_NO_POS_TIME;
    end else begin
      height = gl - y;
      avy = (vy < 0) ? -vy : vy;
      avx = (vx < 0) ? -vx : vx;
      disc = {64'd0, avy} * {64'd0, avy} + {64'd0, height} * {96'd0, t.grav, 1'b0};
      // integer square root, then round up when inexact
      r = '0;
      for (int i = 40; i >= 0; i--) begin
        c = {64'd0, r | (64'd1 << i)};
        if (c * c <= disc) r = c[63:0];
      end
      if ({64'd0, r} * {64'd0, r} != disc) r = r + 1;
      num = $signed(r) - vy;
      prod = {64'd0, avx} * {64'd0, num};
      q = prod / {97'd0, t.grav};
      rem = prod % {97'd0, t.grav};
      if (vx < 0 && rem != 0) q = q + 1;
      lim = 128'd1 << 32;
      if (q > lim) q = lim;
      off = (vx < 0) ? -$signed(q[63:0]) : $signed(q[63:0]);
      ix = x + off;
      if (ix > SMAX) ix = SMAX;
      if (ix < SMIN) ix = SMIN;
      o.impact_x = ix[31:0];
      o.threat = (ix > lf) && (ix < rt);
      o.launch = o.threat & t.idle;
      o.verdict = o.threat ? V_THREAT : V_OUTSIDE;
    end
    return o;
  endfunction

  // offer one track and hold it until the core accepts it
  task automatic send_track(track_t t);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pos_x_i <= t.pos_x;
    pos_y_i <= t.pos_y;
    vel_x_i <= t.vel_x;
    vel_y_i <= t.vel_y;
    grav_i <= t.grav;
    interceptor_idle_i <= t.idle;
    in_valid_i <= 1'b1;
    impact_q.push_back(predict_impact(t));
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (impact_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup then access phase
  task automatic write_reg(logic [1:0] idx, logic signed [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_GROUND: ground_lvl = value;
      REG_LEFT:   left_edge = value;
      REG_RIGHT:  right_edge = value;
      default: ;
    endcase
  endtask

  task automatic set_scene(logic signed [31:0] gl, logic signed [31:0] lf,
                           logic signed [31:0] rt);
    write_reg(REG_GROUND, gl);
    write_reg(REG_LEFT, lf);
    write_reg(REG_RIGHT, rt);
  endtask

  function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v[31:0];
  endfunction

  // random track: fully random bits, or a plausible in-flight projectile
  function automatic track_t random_track();
    track_t t;
    logic signed [63:0] span;
    if ($urandom_range(0, 3) == 0) begin
      t.pos_x = $urandom;
      t.pos_y = $urandom;
      t.vel_x = $urandom;
      t.vel_y = $urandom;
      t.grav = 31'($urandom);
      t.idle = 1'($urandom);
    end else begin
      span = 64'(right_edge) - 64'(left_edge);
      if (span <= 0 || span > 64'sd1 << 30) span = 64'sd1 << 26;
      t.pos_x = clamp32(64'(left_edge) + $urandom_range(0, span[31:0]));
      t.pos_y = clamp32(64'(ground_lvl) - $urandom_range(1, 1 << 25));
      t.vel_x = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
      t.vel_y = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
      t.grav = ($urandom_range(0, 19) == 0) ? '0 : 31'($urandom_range(1, 1 << 20));
      t.idle = 1'($urandom);
    end
    return t;
  endfunction

  // output side: random stall per transaction, long hold-off on request
  initial begin
    int unsigned n;
    outcome_t    e;
    @(posedge rst_ni);
    forever begin
      n = gaps_on ? $urandom_range(0, 16) : 0;
      if (hold_req != 0) begin
        n = hold_req;
        hold_req = 0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      if (impact_q.size() == 0) begin
        $error("result with no track pending: verdict %0d", verdict_o);
        mismatch_cnt++;
      end else begin
        e = impact_q.pop_front();
        if (threat_o !== e.threat) begin
          $error("threat: expected %0d actual %0d", e.threat, threat_o);
          mismatch_cnt++;
        end
        if (launch_o !== e.launch) begin
          $error("launch: expected %0d actual %0d", e.launch, launch_o);
          mismatch_cnt++;
        end
        if (impact_x_o !== e.impact_x) begin
          $error("impact_x: expected %h actual %h", e.impact_x, impact_x_o);
          mismatch_cnt++;
        end
        if (verdict_o !== e.verdict) begin
          $error("verdict: expected %0d actual %0d", e.verdict, verdict_o);
          mismatch_cnt++;
        end
      end
    end
  end

  task automatic test_directed;
    set_scene(32'sd600 <<< 16, 32'sd0, 32'sd800 <<< 16);
    // grounded: exactly at and below ground
    send_track('{32'sd100 <<< 16, 32'sd600 <<< 16, 0, 0, 31'd1 << 16, 1'b1});
    send_track('{32'sd100 <<< 16, SMAX, 0, 0, 31'd1 << 16, 1'b1});
    // left of city takes precedence over zero gravity
    send_track('{-32'sd1, 32'sd0, 0, 0, 31'd0, 1'b1});
    send_track('{SMIN, SMIN, SMAX, SMIN, '1, 1'b0});
    // zero gravity
    send_track('{32'sd100 <<< 16, 32'sd0, 32'sd5 <<< 16, 32'sd3 <<< 16, 31'd0, 1'b1});
    // threats with idle on and off
    send_track('{32'sd400 <<< 16, 32'sd100 <<< 16, 32'sd2 <<< 16, 0, 31'd1 << 16, 1'b1});
    send_track('{32'sd400 <<< 16, 32'sd100 <<< 16, -32'sd2 <<< 16, 0, 31'd1 << 16, 1'b0});
    // falls right and left of city
    send_track('{32'sd790 <<< 16, 32'sd0, 32'sd50 <<< 16, -32'sd3 <<< 16, 31'd1 << 14, 1'b1});
    send_track('{32'sd5 <<< 16, 32'sd0, -32'sd50 <<< 16, 0, 31'd1 << 14, 1'b1});
    // saturation both ways, extreme gravity and velocities
    send_track('{32'sd100 <<< 16, SMIN, SMAX, SMIN, 31'd1, 1'b1});
    send_track('{32'sd100 <<< 16, SMIN, SMIN, SMAX, 31'd1, 1'b1});
    send_track('{SMAX, 32'sd599 <<< 16, SMAX, SMAX, '1, 1'b1});
    send_track('{32'sd0, 32'sd600 <<< 16 - 1, SMIN, SMIN, '1, 1'b1});
    send_track('{32'sd1, 32'sd0, -32'sd1, 32'sd0, 31'd3, 1'b1});
    drain();
    // extreme register settings
    set_scene(SMAX, SMIN, SMAX);
    send_track('{SMIN, SMIN, SMAX, SMAX, 31'd1, 1'b1});
    send_track('{SMAX, SMAX - 1, SMIN, SMIN, '1, 1'b1});
    send_track('{32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd1, 1'b1});
    drain();
    set_scene(SMIN, SMAX, SMIN);
    send_track('{SMAX, SMIN, 0, 0, 31'd1, 1'b1});
    send_track('{32'sd0, 32'sd0, 0, 0, 31'd1, 1'b1});
    drain();
  endtask

  // block fills up while the output side holds off
  task automatic test_backpressure;
    set_scene(32'sd600 <<< 16, 32'sd0, 32'sd800 <<< 16);
    gaps_on = 1'b0;
    hold_req = 300;
    repeat (150) send_track(random_track());
    drain();
    gaps_on = 1'b1;
  endtask

  task automatic test_random;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_scene(32'sd600 <<< 16, 32'sd0, 32'sd800 <<< 16);
        1: set_scene(SMAX, SMIN, SMAX);
        2: set_scene(SMIN, SMIN, SMAX);
        3: set_scene(32'sd0, -32'sd1000 <<< 16, 32'sd1000 <<< 16);
        4: set_scene(SMAX, SMAX, SMIN);
        default: set_scene($urandom, -$signed($urandom_range(0, 1 << 28)),
                           $urandom_range(0, 1 << 28));
      endcase
      for (int i = 0; i < 185; i++) begin
        if (i % 50 == 0) gaps_on = ($urandom_range(0, 3) != 0);
        send_track(random_track());
      end
      drain();
      gaps_on = 1'b1;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random();
    repeat (100) @(posedge clk_i);
    if (mismatch_cnt == 0 && impact_q.size() == 0) begin
      $display("ballistic_impact_threat_check_core_test: clean");
    end else begin
      $display("ballistic_impact_threat_check_core_test: errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("ballistic_impact_threat_check_core_test: errors");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/btc_pkg.sv
src/btc_front.sv
src/btc_queue.sv
src/btc_back.sv
src/ballistic_impact_threat_check_core.sv
tb/ballistic_impact_threat_check_core_test.sv
